/* design/sac_pkg.sv */
// Shared constants and types for the set-associative cache model block.
package sac_pkg;

	// Default sizing handed to the top level
	localparam int MAX_SETS_DEF     = 64;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int ADDRESS_BITS_DEF = 48;

	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 4;

	// Largest usable block offset
	localparam logic [3:0] OFFSET_MAX = 4'd12;

	// Register reset values
	localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
	localparam logic [2:0] INDEX_BITS_RST  = 3'd6;
	localparam logic [3:0] WAYS_RST        = 4'd8;
	localparam logic       LRU_MODE_RST    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2,
		CFG_LRU_MODE    = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOOK = 2'b10
	} state_t;

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

endpackage

/* design/set_associative_cache_sim_top.sv */
// Set-associative cache lookup with LRU or FIFO replacement and access counters.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid / in_ready    | operation, address
//  out      | out_valid / out_ready  | hit, memory_reads, memory_writes,
//           |                        | hit_count, miss_count
//  cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// The tag and state rows of an item's set are read at acceptance; the lookup state then
// compares, picks the way and writes the state row back, and the tag row on a miss.
// The row memories have one port each, so one item is in flight at a time.
// Reset clears the counters and one valid flag per set row and loads the registers' reset values; no clearing pass.
// A result waiting in the output register stalls the write-back cycle only when a
// second item completes before the first is taken.
module set_associative_cache_sim_top #(
	parameter int MAX_SETS     = sac_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
	parameter int ADDRESS_BITS = sac_pkg::ADDRESS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sac_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [ADDRESS_BITS-1:0]       address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          hit,
	output logic [sac_pkg::CNT_W-1:0]     memory_reads,
	output logic [sac_pkg::CNT_W-1:0]     memory_writes,
	output logic [sac_pkg::CNT_W-1:0]     hit_count,
	output logic [sac_pkg::CNT_W-1:0]     miss_count
);
	import sac_pkg::*;

	localparam int SET_W        = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AGE_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [3:0]       SET_BITS_MAX_L = 4'(SET_BITS_MAX);
	localparam logic [AGE_W-1:0] AGE_MAX        = AGE_W'(MAX_WAYS - 1);

	typedef logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] tag_row_t;
	typedef struct packed {
		logic [MAX_WAYS-1:0]            vld;
		logic [MAX_WAYS-1:0][AGE_W-1:0] age;
	} meta_row_t;

	// Row memories, one row per set
	tag_row_t  tag_mem  [MAX_SETS];
	meta_row_t meta_mem [MAX_SETS];
	tag_row_t  tag_rd_q;
	meta_row_t meta_rd_q;

	state_t state_q;
	logic [MAX_SETS-1:0] row_ok_q;

	logic [3:0] offset_bits_q;
	logic [2:0] index_bits_q;
	logic [3:0] ways_q;
	logic       lru_q;

	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] writes_q;
	logic             out_valid_q;
	logic             hit_q;

	logic                    op_s1;
	logic [SET_W-1:0]        set_s1;
	logic [ADDRESS_BITS-1:0] tag_s1;

	logic                    acc;
	logic                    done;
	logic [3:0]              ob;
	logic [3:0]              ib;
	logic [4:0]              tag_sh;
	logic [ADDRESS_BITS-1:0] addr_sh;
	logic [SET_W-1:0]        set_mask;
	logic [SET_W-1:0]        acc_set;
	logic [ADDRESS_BITS-1:0] acc_tag;

	logic [MAX_WAYS-1:0] in_use;
	logic [MAX_WAYS-1:0] match;
	meta_row_t           meta_cur;
	meta_row_t           meta_new;
	tag_row_t            tag_new;
	logic                hit_c;
	logic                has_free;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    old_way;
	logic [WAY_W-1:0]    slot;
	logic [AGE_W-1:0]    hit_age;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign done     = (state_q == ST_LOOK) && (!out_valid_q || out_ready);

	// Address split
	assign ob       = (offset_bits_q > OFFSET_MAX) ? OFFSET_MAX : offset_bits_q;
	assign ib       = ({1'b0, index_bits_q} > SET_BITS_MAX_L) ? SET_BITS_MAX_L
	                                                          : {1'b0, index_bits_q};
	assign tag_sh   = 5'(ob) + 5'(ib);
	assign addr_sh  = address >> ob;
	assign set_mask = ~({SET_W{1'b1}} << ib);
	assign acc_set  = addr_sh[SET_W-1:0] & set_mask;
	assign acc_tag  = address >> tag_sh;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			in_use[w] = (ways_q == 4'd0) ? (w == 0) : (int'(ways_q) > w);
		end
	end

	// Lookup and replacement on the rows read back
	always_comb begin
		meta_cur = row_ok_q[set_s1] ? meta_rd_q : '0;
		hit_way  = '0;
		free_way = '0;
		has_free = 1'b0;
		old_way  = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			match[w] = in_use[w] && meta_cur.vld[w] && (tag_rd_q[w] == tag_s1);
		end
		hit_c = |match;
		// scan downward so the lowest way wins
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (in_use[w] && !meta_cur.vld[w]) begin
				free_way = WAY_W'(w);
				has_free = 1'b1;
			end
		end
		for (int w = 1; w < MAX_WAYS; w++) begin
			if (in_use[w] && (meta_cur.age[w] > meta_cur.age[old_way])) begin
				old_way = WAY_W'(w);
			end
		end
		slot    = has_free ? free_way : old_way;
		hit_age = meta_cur.age[hit_way];

		meta_new = meta_cur;
		tag_new  = tag_rd_q;
		if (hit_c) begin
			if (lru_q) begin
				for (int w = 0; w < MAX_WAYS; w++) begin
					if (in_use[w] && meta_cur.vld[w] && (meta_cur.age[w] < hit_age)
					    && (meta_cur.age[w] < AGE_MAX)) begin
						meta_new.age[w] = meta_cur.age[w] + 1'b1;
					end
				end
				meta_new.age[hit_way] = '0;
			end
		end else begin
			// age every other valid way, then fill the chosen slot
			for (int w = 0; w < MAX_WAYS; w++) begin
				if (in_use[w] && meta_cur.vld[w] && (WAY_W'(w) != slot)
				    && (meta_cur.age[w] < AGE_MAX)) begin
					meta_new.age[w] = meta_cur.age[w] + 1'b1;
				end
			end
			meta_new.vld[slot] = 1'b1;
			meta_new.age[slot] = '0;
			tag_new[slot]      = tag_s1;
		end
	end

	// Row memories: read at acceptance, write back when the item completes
	always_ff @(posedge clk) begin
		if (acc) begin
			tag_rd_q  <= tag_mem[acc_set];
			meta_rd_q <= meta_mem[acc_set];
		end
		if (done) begin
			meta_mem[set_s1] <= meta_new;
			if (!hit_c) begin
				tag_mem[set_s1] <= tag_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1  <= operation;
			set_s1 <= acc_set;
			tag_s1 <= acc_tag;
		end
		if (done) begin
			hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			row_ok_q      <= '0;
			offset_bits_q <= OFFSET_BITS_RST;
			index_bits_q  <= INDEX_BITS_RST;
			ways_q        <= WAYS_RST;
			lru_q         <= LRU_MODE_RST;
			hits_q        <= '0;
			misses_q      <= '0;
			writes_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
					CFG_INDEX_BITS:  index_bits_q  <= cfg_data[2:0];
					CFG_WAYS_IN_USE: ways_q        <= cfg_data;
					CFG_LRU_MODE:    lru_q         <= cfg_data[0];
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (done) begin
				row_ok_q[set_s1] <= 1'b1;
				out_valid_q      <= 1'b1;
				if (op_s1 == OP_WRITE && writes_q != '1) begin
					writes_q <= writes_q + 1'b1;
				end
				if (hit_c) begin
					if (hits_q != '1) begin
						hits_q <= hits_q + 1'b1;
					end
				end else if (misses_q != '1) begin
					misses_q <= misses_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Counters change only while no result is held or the held one is taken, so they drive the outputs directly
	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign memory_reads  = misses_q;
	assign memory_writes = writes_q;
	assign hit_count     = hits_q;
	assign miss_count    = misses_q;

`ifndef SYNTH
	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == ST_LOOK))
		else $error("accepted item did not enter lookup");

	a_hit_keeps_misses: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit_c) |=> (misses_q == $past(misses_q)))
		else $error("miss counter moved on a hit");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> row_ok_q[$past(set_s1)])
		else $error("written set row not marked valid");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q >= $past(hits_q))
		else $error("hit counter decreased");
`endif

endmodule

/* sim/cache_checker.sv */
// Access predictor and result checker for the set-associative cache block.
`timescale 1ns / 100ps

module cache_checker #(
	parameter int MAX_SETS     = sac_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
	parameter int ADDRESS_BITS = sac_pkg::ADDRESS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sac_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          operation,
	input  logic [ADDRESS_BITS-1:0]       address,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          hit,
	input  logic [sac_pkg::CNT_W-1:0]     memory_reads,
	input  logic [sac_pkg::CNT_W-1:0]     memory_writes,
	input  logic [sac_pkg::CNT_W-1:0]     hit_count,
	input  logic [sac_pkg::CNT_W-1:0]     miss_count,
	output int                            fail_count,
	output int                            pending
);
	import sac_pkg::*;

	localparam int DEPTH = MAX_SETS * MAX_WAYS;

	typedef struct {
		logic             hit;
		logic [CNT_W-1:0] reads;
		logic [CNT_W-1:0] writes;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
	} access_result_t;

	access_result_t expected_results[$];

	logic [ADDRESS_BITS-1:0] tag_mem [DEPTH];
	bit                      valid_mem [DEPTH];
	int                      rank_mem [DEPTH];
	logic [CNT_W-1:0]        hits_total;
	logic [CNT_W-1:0]        misses_total;
	logic [CNT_W-1:0]        writes_total;

	logic [3:0] offset_reg;
	logic [2:0] index_reg;
	logic [3:0] ways_reg;
	logic       lru_reg;

	int result_no;

	initial begin
		fail_count = 0;
		pending = 0;
		result_no = 0;
	end

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] MISMATCH result %0d %s: got %0h expected %0h",
			$time, result_no, what, got, want);
		fail_count++;
	endtask

	// Push every valid in-use way of the set one step older, up to limit.
	task automatic age_ways(int base, int ways, int limit);
		int w;
		for (w = 0; w < ways; w++) begin
			if (valid_mem[base + w] && rank_mem[base + w] < limit &&
				rank_mem[base + w] < MAX_WAYS - 1)
				rank_mem[base + w]++;
		end
	endtask

	task automatic predict_access(input logic op, input logic [ADDRESS_BITS-1:0] addr,
		output access_result_t res);
		int ob, ib, ways, set_no, base, e, slot, best, r, w;
		logic [ADDRESS_BITS-1:0] shifted, tag;
		bit found;
		ob = (offset_reg > OFFSET_MAX) ? int'(OFFSET_MAX) : int'(offset_reg);
		ib = int'(index_reg);
		while (ib > 0 && (1 << ib) > MAX_SETS)
			ib--;
		ways = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg));
		shifted = addr >> ob;
		set_no = int'(shifted & ((64'd1 << ib) - 64'd1));
		tag = addr >> (ob + ib);
		if (set_no >= MAX_SETS)
			set_no = 0;
		base = set_no * MAX_WAYS;

		if (op == OP_WRITE)
			writes_total = sat_inc(writes_total);

		found = 0;
		e = base;
		for (w = 0; w < ways; w++) begin
			if (!found && valid_mem[base + w] && tag_mem[base + w] == tag) begin
				found = 1;
				e = base + w;
			end
		end

		if (found) begin
			hits_total = sat_inc(hits_total);
			if (lru_reg) begin
				r = rank_mem[e];
				age_ways(base, ways, r);
				rank_mem[e] = 0;
			end
		end else begin
			misses_total = sat_inc(misses_total);
			slot = ways;
			for (w = 0; w < ways; w++) begin
				if (slot == ways && !valid_mem[base + w])
					slot = w;
			end
			// No free way: evict the oldest, lowest way on a tie
			if (slot == ways) begin
				best = 0;
				for (w = 1; w < ways; w++) begin
					if (rank_mem[base + w] > rank_mem[base + best])
						best = w;
				end
				slot = best;
				valid_mem[base + slot] = 0;
			end
			age_ways(base, ways, 256);
			e = base + slot;
			tag_mem[e] = tag;
			valid_mem[e] = 1;
			rank_mem[e] = 0;
		end

		res.hit = found;
		res.reads = misses_total;
		res.writes = writes_total;
		res.hits = hits_total;
		res.misses = misses_total;
	endtask

	task automatic clear_model();
		int i;
		for (i = 0; i < DEPTH; i++) begin
			tag_mem[i] = '0;
			valid_mem[i] = 0;
			rank_mem[i] = 0;
		end
		hits_total = '0;
		misses_total = '0;
		writes_total = '0;
		offset_reg = OFFSET_BITS_RST;
		index_reg = INDEX_BITS_RST;
		ways_reg = WAYS_RST;
		lru_reg = LRU_MODE_RST;
		expected_results.delete();
		pending = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		access_result_t next_res;
		if (!arst_n) begin
			clear_model();
		end else begin
			// Retire before predicting: a result never belongs to an item taken at the same edge
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no access pending", 0, 0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", hit, want.hit);
					if (memory_reads !== want.reads)
						report_mismatch("memory_reads", memory_reads, want.reads);
					if (memory_writes !== want.writes)
						report_mismatch("memory_writes", memory_writes, want.writes);
					if (hit_count !== want.hits)
						report_mismatch("hit_count", hit_count, want.hits);
					if (miss_count !== want.misses)
						report_mismatch("miss_count", miss_count, want.misses);
				end
				result_no++;
			end
			if (in_valid && in_ready) begin
				predict_access(operation, address, next_res);
				expected_results.push_back(next_res);
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_OFFSET_BITS: offset_reg = cfg_data[3:0];
					CFG_INDEX_BITS:  index_reg = cfg_data[2:0];
					CFG_WAYS_IN_USE: ways_reg = cfg_data[3:0];
					CFG_LRU_MODE:    lru_reg = cfg_data[0];
					default: ;
				endcase
			end
			pending = expected_results.size();
		end
	end

endmodule

/* sim/tb.sv */
// Stimulus and verdict for the set-associative cache block.
`timescale 1ns / 100ps

module tb;
	import sac_pkg::*;

	localparam int MAX_SETS     = MAX_SETS_DEF;
	localparam int MAX_WAYS     = MAX_WAYS_DEF;
	localparam int ADDRESS_BITS = ADDRESS_BITS_DEF;
	localparam int HI_W         = ADDRESS_BITS - 32;
	localparam int PHASE_ITEMS  = 110;
	localparam int POOL_DEPTH   = 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum int {RX_FREE, RX_OPEN, RX_COIN, RX_SLOW} rx_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DAT_W-1:0]    cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    operation;
	logic [ADDRESS_BITS-1:0] address;
	logic                    out_valid;
	logic                    out_ready;
	logic                    hit;
	logic [CNT_W-1:0]        memory_reads;
	logic [CNT_W-1:0]        memory_writes;
	logic [CNT_W-1:0]        hit_count;
	logic [CNT_W-1:0]        miss_count;
	int                      fail_count;
	int                      pending;
	int                      cycle_count = 0;

	// Register values as last written, used only to shape addresses
	int cur_offset = OFFSET_BITS_RST;
	int cur_index  = INDEX_BITS_RST;
	int cur_ways   = WAYS_RST;

	logic [ADDRESS_BITS-1:0] tag_pool [POOL_DEPTH];
	int pool_ob = -1;
	int pool_ib = -1;

	set_associative_cache_sim_top #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .memory_reads(memory_reads), .memory_writes(memory_writes),
		.hit_count(hit_count), .miss_count(miss_count)
	);

	cache_checker #(
		.MAX_SETS(MAX_SETS),
		.MAX_WAYS(MAX_WAYS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .address(address),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .memory_reads(memory_reads), .memory_writes(memory_writes),
		.hit_count(hit_count), .miss_count(miss_count),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("set_associative_cache_sim_top test failed");
			$finish;
		end
	end

	// Receiver: switch between free flow, random stalls and slow drain
	initial begin
		rx_mode_t mode;
		int mode_left;
		mode = RX_FREE;
		mode_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (mode)
				RX_FREE, RX_OPEN: out_ready = 1'b1;
				RX_COIN:          out_ready = $urandom_range(0, 1);
				RX_SLOW:          out_ready = ($urandom_range(0, 3) == 0);
				default:          out_ready = 1'b1;
			endcase
		end
	end

	function automatic logic [ADDRESS_BITS-1:0] rand_addr();
		logic [ADDRESS_BITS-1:0] a;
		a[31:0] = $urandom;
		a[ADDRESS_BITS-1:32] = HI_W'($urandom);
		return a;
	endfunction

	function automatic logic [ADDRESS_BITS-1:0] make_addr(logic [ADDRESS_BITS-1:0] tag,
		int set_no, logic [ADDRESS_BITS-1:0] off, int ob, int ib);
		logic [ADDRESS_BITS-1:0] set_field;
		logic [ADDRESS_BITS-1:0] low_mask;
		set_field = ADDRESS_BITS'(set_no);
		low_mask = (ADDRESS_BITS'(1) << ob) - 1'b1;
		return (tag << (ob + ib)) | (set_field << ob) | (off & low_mask);
	endfunction

	// Hold the item until it is taken; valid stays high for a following item
	task automatic send_access(logic op, logic [ADDRESS_BITS-1:0] addr);
		in_valid = 1'b1;
		operation = op;
		address = addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_off(int cycles);
		in_valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_config(int offset_val, int index_val, int ways_val, int lru_val);
		drain();
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_OFFSET_BITS;
		cfg_data = CFG_DAT_W'(offset_val);
		@(negedge clk);
		cfg_index = CFG_INDEX_BITS;
		cfg_data = CFG_DAT_W'(index_val);
		@(negedge clk);
		cfg_index = CFG_WAYS_IN_USE;
		cfg_data = CFG_DAT_W'(ways_val);
		@(negedge clk);
		cfg_index = CFG_LRU_MODE;
		cfg_data = CFG_DAT_W'(lru_val);
		@(negedge clk);
		cfg_we = 1'b0;
		cur_offset = offset_val & 15;
		cur_index = index_val & 7;
		cur_ways = ways_val & 15;
	endtask

	task automatic run_phase(int n_items);
		int ob, ib, ways, nsets, hot_sets, pool_size, burst, k, set_no, i;
		logic [ADDRESS_BITS-1:0] addr;
		ob = (cur_offset > OFFSET_MAX) ? int'(OFFSET_MAX) : cur_offset;
		ib = cur_index;
		while (ib > 0 && (1 << ib) > MAX_SETS)
			ib--;
		ways = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
		nsets = 1 << ib;
		hot_sets = (nsets < 4) ? nsets : 4;
		// Keep the tags while the split is unchanged, so a change of ways can leave duplicates
		if (ob != pool_ob || ib != pool_ib) begin
			for (i = 0; i < POOL_DEPTH; i++)
				tag_pool[i] = rand_addr();
			pool_ob = ob;
			pool_ib = ib;
		end
		pool_size = ways + $urandom_range(0, 3);
		burst = 0;
		for (i = 0; i < n_items; i++) begin
			if (burst == 0) begin
				if ($urandom_range(0, 59) == 0)
					drain();
				else if ($urandom_range(0, 2) != 0)
					hold_off($urandom_range(1, 6));
				burst = $urandom_range(1, 24);
			end
			burst--;
			k = $urandom_range(0, 99);
			if (k < 88) begin
				set_no = (k < 72) ? $urandom_range(0, hot_sets - 1) : $urandom_range(0, nsets - 1);
				addr = make_addr(tag_pool[$urandom_range(0, pool_size - 1)], set_no,
					rand_addr(), ob, ib);
			end else begin
				addr = rand_addr();
			end
			send_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, addr);
		end
	endtask

	task automatic config_and_run(int offset_val, int index_val, int ways_val, int lru_val);
		set_config(offset_val, index_val, ways_val, lru_val);
		run_phase(PHASE_ITEMS);
	endtask

	initial begin
		int t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_OFFSET_BITS;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_READ;
		address = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: address extremes, offset within a block, fill and evict one set
		send_access(OP_READ, '0);
		send_access(OP_WRITE, '1);
		send_access(OP_WRITE, '0);
		send_access(OP_READ, '1);
		send_access(OP_READ, ADDRESS_BITS'(63));
		for (t = 1; t <= 9; t++)
			send_access(OP_READ, make_addr(ADDRESS_BITS'(t), 5, '0, 6, 6));
		send_access(OP_READ, make_addr(ADDRESS_BITS'(2), 5, '0, 6, 6));
		send_access(OP_READ, make_addr(ADDRESS_BITS'(1), 5, '0, 6, 6));
		send_access(OP_WRITE, make_addr(ADDRESS_BITS'(2), 5, '0, 6, 6));
		drain();

		config_and_run(6, 6, 8, 1);
		config_and_run(0, 0, 1, 0);
		config_and_run(12, 6, 8, 0);
		config_and_run(15, 7, 15, 1);
		config_and_run(0, 6, 0, 1);
		config_and_run(3, 2, 4, 0);
		config_and_run(12, 0, 8, 1);
		config_and_run(5, 3, 8, 1);
		config_and_run(5, 3, 2, 0);
		config_and_run(5, 3, 8, 1);
		config_and_run(9, 15, 14, 14);
		repeat (4)
			config_and_run($urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 15), $urandom_range(0, 15));

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("set_associative_cache_sim_top test passed");
		end else begin
			$display("set_associative_cache_sim_top test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
design/sac_pkg.sv
design/set_associative_cache_sim_top.sv
sim/cache_checker.sv
sim/tb.sv
